### hw/rtl/dsp_pkg.sv
// shared widths, constants and divider interface types for the divisor-sum block
package dsp_pkg;

    // payload widths
    localparam int NUM_W     = 16;
    localparam int SUM_W     = 18;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - SUM_W - 1;

    // internal datapath widths
    localparam int PROD_W = 20;             // full sigma below 65536 fits in 19 bits
    localparam int TERM_W = 18;             // 1 + p + ... + p^k stays below 2^17
    localparam int DVS_W  = 9;              // trial divisors run 2..256
    localparam int REM_W  = DVS_W;
    localparam int DIV_STEPS = NUM_W;       // one quotient bit per cycle
    localparam int CNT_W  = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
        logic [REM_W-1:0] rem;
    } t_div_rsp;

endpackage

### hw/rtl/dsp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module dsp_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dsp_pkg::t_div_req i_req,
    output dsp_pkg::t_div_rsp o_rsp
);
    import dsp_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_work;
    logic [REM_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [REM_W:0]   w_trial;
    logic             w_ge;
    logic [REM_W:0]   w_diff;

    // trial subtract of the shifted partial remainder
    assign w_trial = {r_rem, r_work[NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= {r_work[NUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;
    assign o_rsp.rem  = r_rem;

endmodule

### hw/rtl/divisor_sum_perfect_test.sv
// divisor sum and perfect-number test, top level
// Takes one 16-bit number per beat and returns sigma(number) on 18 bits, saturated at
// 262143, with a flag set when sigma equals twice the number; input 0 gives 0 and 0.
// The number is factored by trial division with every divisor d from 2 while d*d
// stays within the unfactored rest, using one shared bit-serial divider. The input
// is not ready while an item is being worked on; a finished result sits in an
// output register and the next item is taken while it waits.
module divisor_sum_perfect_test (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [dsp_pkg::S_TDATA_W-1:0]  i_s_tdata,   // [15:0] number
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dsp_pkg::M_TDATA_W-1:0]  o_m_tdata    // [17:0] divisor_sum, [18] is_perfect
);
    import dsp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_ISSUE = 6'b000100,
        S_DIV   = 6'b001000,
        S_MUL   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [NUM_W-1:0]  r_n;
    logic [NUM_W-1:0]  r_rest;
    logic [DVS_W-1:0]  r_d;
    logic [TERM_W-1:0] r_term;
    logic [PROD_W-1:0] r_prod;
    logic              r_last;
    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_perf;

    t_div_req          w_req;
    t_div_rsp          w_rsp;

    logic                    w_in_beat;
    logic                    w_out_free;
    logic [2*DVS_W-1:0]      w_dsq;
    logic                    w_stop;
    logic [TERM_W+DVS_W-1:0] w_term_mul;
    logic [TERM_W-1:0]       w_term_step;
    logic [PROD_W+TERM_W-1:0] w_prod_mul;
    logic [SUM_W-1:0]        w_sum_sat;
    logic                    w_perf;

    // shared divider
    assign w_req.start    = (r_state == S_ISSUE);
    assign w_req.dividend = r_rest;
    assign w_req.divisor  = r_d;

    dsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // handshake helpers
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_beat  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // trial divisor bound: stop once d*d exceeds the rest
    assign w_dsq  = r_d * r_d;
    assign w_stop = w_dsq > {{(2*DVS_W-NUM_W){1'b0}}, r_rest};

    // term grows as term*p + 1 per divided-out prime
    assign w_term_mul  = r_term * r_d;
    assign w_term_step = w_term_mul[TERM_W-1:0] + TERM_W'(1);
    assign w_prod_mul  = r_prod * r_term;

    // result formatting, zero is never perfect
    assign w_sum_sat = (r_prod > PROD_W'(SUM_MAX)) ? SUM_MAX : r_prod[SUM_W-1:0];
    assign w_perf    = (r_n != '0) && (r_prod == PROD_W'({r_n, 1'b0}));

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_beat) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!w_stop) n_state = S_ISSUE;
                else if (r_rest > NUM_W'(1)) n_state = S_MUL;
                else n_state = S_FIN;
            end
            S_ISSUE: n_state = S_DIV;
            S_DIV: begin
                if (w_rsp.done) begin
                    if (w_rsp.rem == '0) n_state = S_ISSUE;
                    else n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_last) n_state = S_FIN;
                else n_state = S_CHECK;
            end
            S_FIN: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN && w_out_free) r_out_valid <= 1'b1;
            else if (o_m_tvalid && i_m_tready) r_out_valid <= 1'b0;
        end
    end

    // factoring datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_n    <= i_s_tdata[NUM_W-1:0];
                r_rest <= i_s_tdata[NUM_W-1:0];
                r_d    <= DVS_W'(2);
                r_term <= TERM_W'(1);
                r_prod <= (i_s_tdata[NUM_W-1:0] == '0) ? '0 : PROD_W'(1);
                r_last <= 1'b0;
            end
            S_CHECK: begin
                // leftover rest above one is a single prime
                if (w_stop && r_rest > NUM_W'(1)) begin
                    r_term <= TERM_W'(r_rest) + TERM_W'(1);
                    r_last <= 1'b1;
                end
            end
            S_DIV: begin
                if (w_rsp.done && w_rsp.rem == '0) begin
                    r_rest <= w_rsp.quot;
                    r_term <= w_term_step;
                end
            end
            S_MUL: begin
                r_prod <= w_prod_mul[PROD_W-1:0];
                r_term <= TERM_W'(1);
                r_d    <= r_d + DVS_W'(1);
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_out_sum  <= w_sum_sat;
            r_out_perf <= w_perf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{M_PAD_W{1'b0}}, r_out_perf, r_out_sum};

`ifndef SYNTHESIS
    // an accepted beat closes the input until the item is finished
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !o_s_tready)
        else $error("input ready right after an accepted beat");

    // divider only answers while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside the wait state");

    // a perfect number has an even divisor sum
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[SUM_W]) |-> !o_m_tdata[0])
        else $error("perfect flag with odd divisor sum");

    // trial divisors never drop below two while dividing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_d >= DVS_W'(2)))
        else $error("trial divisor below two");
`endif

endmodule
